// File: design/acmdc_pkg.sv
// ----------------------------------------------------------------------------
// acmdc_pkg
// Shared types and constants of the reversing motor sequencer.
// ----------------------------------------------------------------------------
package acmdc_pkg;

  localparam int unsigned PulseWidthDef = 16;
  localparam int unsigned QuotW         = 16;
  localparam int unsigned CntW          = $clog2(QuotW + 1);

  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;
  localparam logic [15:0] RPM_MAX    = 16'hFFFF;

  localparam logic [7:0] SPIN_OFF_RST = 8'd10;
  localparam logic [7:0] PPR_RST      = 8'd1;

  localparam logic CFG_SPIN_OFF = 1'b0;
  localparam logic CFG_PPR      = 1'b1;

  typedef enum logic [2:0] {
    ACT_REFRESH  = 3'd0,
    ACT_RPM_TICK = 3'd1,
    ACT_PULSE    = 3'd2,
    ACT_FWD_REQ  = 3'd3,
    ACT_BWD_REQ  = 3'd4,
    ACT_STOP_REQ = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BWD  = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  typedef struct packed {
    logic apply;
    logic tick_start;
    logic prep;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_idle;
    logic div_last;
  } dp_status_t;

  typedef struct packed {
    logic [15:0] speed_rpm;
    logic        running;
    logic        coil_two_relay;
    logic        coil_one_relay;
    logic        brush_relay;
    logic        power_relay;
    logic [1:0]  motor_mode;
  } result_t;

endpackage

// File: design/acmdc_ctrl.sv
// ----------------------------------------------------------------------------
// acmdc_ctrl
// Sequencer for request acceptance, rpm division steps and result hand-off.
// ----------------------------------------------------------------------------
module acmdc_ctrl import acmdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] in_action_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_READY = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   tick_work;

  assign in_ready_o  = (state_q == ST_READY) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign tick_work   = (in_action_i == ACT_RPM_TICK) && !status_i.mode_idle;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.apply      = accept && !tick_work;
    cmd_o.tick_start = accept && tick_work;
    cmd_o.prep       = (state_q == ST_PREP);
    cmd_o.step       = (state_q == ST_DIV);
    cmd_o.finish     = (state_q == ST_DONE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READY: begin
        if (cmd_o.tick_start) state_d = ST_PREP;
      end
      ST_PREP:  state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE:  state_d = ST_READY;
      default:  state_d = ST_READY;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.apply || cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the result slot stays empty while an rpm division is in flight
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_READY) |-> !out_valid_q)
    else $error("result pending during division");

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> out_valid_q)
    else $error("division finished without result");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.div_last) |=> (state_q == ST_DONE))
    else $error("division did not finish after last step");

endmodule

// File: design/acmdc_datapath.sv
// ----------------------------------------------------------------------------
// acmdc_datapath
// Mode and request registers, pulse counter and restoring rpm divider.
// ----------------------------------------------------------------------------
module acmdc_datapath import acmdc_pkg::*; #(
  parameter int unsigned PULSE_WIDTH = PulseWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [2:0]  action_i,
  input  logic        fwd_down_i,
  input  logic        bwd_down_i,
  input  logic [31:0] now_ms_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output result_t     result_o
);

  localparam int unsigned NumW = PULSE_WIDTH + 16;
  localparam int unsigned DenW = 40;
  localparam int unsigned ShW  = DenW + QuotW;
  localparam int unsigned PadW = ShW - NumW;

  mode_e               mode_q, mode_d;
  logic                fwd_held_q, fwd_held_d, bwd_held_q, bwd_held_d;
  logic                fwd_pend_q, fwd_pend_d, bwd_pend_q, bwd_pend_d;
  logic                stop_pend_q, stop_pend_d;
  logic [31:0]         entry_q, entry_d;
  logic [31:0]         sample_q, sample_d;
  logic [PULSE_WIDTH-1:0] pulse_q, pulse_d;
  logic [15:0]         rpm_q, rpm_d;
  logic [7:0]          spin_q, ppr_q;

  logic [NumW-1:0]     num_q, rem_q;
  logic [DenW-1:0]     den_q;
  logic [ShW-1:0]      dsr_q;
  logic [QuotW-1:0]    quot_q;
  logic                sat_q;
  logic [CntW-1:0]     cnt_q;
  logic [31:0]         now_q;

  logic [17:0]         spin_ms;
  logic                expired;
  logic                ge;
  logic [31:0]         elapsed_ms;

  assign spin_ms    = 18'(spin_q) * 18'(MS_PER_SEC);
  assign expired    = (now_ms_i - entry_q) > 32'(spin_ms);
  assign ge         = {{PadW{1'b0}}, rem_q} >= dsr_q;
  // elapsed time wraps at 32 bits
  assign elapsed_ms = now_ms_i - sample_q;

  assign status_o.mode_idle = (mode_q == MODE_IDLE);
  assign status_o.div_last  = (cnt_q == '0);

  always_comb begin
    result_o                = '0;
    result_o.motor_mode     = mode_q;
    result_o.power_relay    = (mode_q == MODE_FWD) || (mode_q == MODE_BWD);
    result_o.brush_relay    = (mode_q == MODE_BWD);
    result_o.coil_one_relay = (mode_q == MODE_BWD);
    result_o.coil_two_relay = (mode_q == MODE_BWD);
    result_o.running        = (mode_q == MODE_FWD) || (mode_q == MODE_BWD);
    result_o.speed_rpm      = rpm_q;
  end

  // refresh walks the same steps in order; entry_chg marks a fresh entry time,
  // after which the spin-off window cannot have run out
  always_comb begin
    logic entry_chg;
    entry_chg   = 1'b0;
    mode_d      = mode_q;
    fwd_held_d  = fwd_held_q;
    bwd_held_d  = bwd_held_q;
    fwd_pend_d  = fwd_pend_q;
    bwd_pend_d  = bwd_pend_q;
    stop_pend_d = stop_pend_q;
    entry_d     = entry_q;
    sample_d    = sample_q;
    pulse_d     = pulse_q;
    rpm_d       = rpm_q;
    if (cmd_i.apply) begin
      case (action_i)
        ACT_REFRESH: begin
          if (fwd_down_i) begin
            fwd_held_d = 1'b1;
            fwd_pend_d = 1'b1;
          end else if (fwd_held_d) begin
            fwd_held_d  = 1'b0;
            fwd_pend_d  = 1'b0;
            stop_pend_d = 1'b1;
          end
          if (bwd_down_i) begin
            bwd_held_d = 1'b1;
            bwd_pend_d = 1'b1;
          end else if (bwd_held_d) begin
            bwd_held_d  = 1'b0;
            bwd_pend_d  = 1'b0;
            stop_pend_d = 1'b1;
          end
          if (stop_pend_d) begin
            stop_pend_d = 1'b0;
            if (mode_d != MODE_IDLE) begin
              if (mode_d != MODE_STOP) begin
                entry_d = now_ms_i; entry_chg = 1'b1; mode_d = MODE_STOP;
              end else if (!entry_chg && expired) begin
                entry_d = now_ms_i; entry_chg = 1'b1; mode_d = MODE_IDLE;
              end
            end
          end
          if (fwd_pend_d && mode_d != MODE_STOP) begin
            if (mode_d == MODE_IDLE) begin
              entry_d = now_ms_i; entry_chg = 1'b1;
              pulse_d = '0; rpm_d = '0; sample_d = now_ms_i;
              fwd_pend_d = 1'b0; mode_d = MODE_FWD;
            end else if (mode_d != MODE_FWD) begin
              fwd_pend_d = 1'b1;
              entry_d = now_ms_i; entry_chg = 1'b1; mode_d = MODE_STOP;
            end
          end
          if (bwd_pend_d && mode_d != MODE_STOP) begin
            if (mode_d == MODE_IDLE) begin
              entry_d = now_ms_i; entry_chg = 1'b1;
              pulse_d = '0; rpm_d = '0; sample_d = now_ms_i;
              bwd_pend_d = 1'b0; mode_d = MODE_BWD;
            end else if (mode_d != MODE_BWD) begin
              bwd_pend_d = 1'b1;
              entry_d = now_ms_i; entry_chg = 1'b1; mode_d = MODE_STOP;
            end
          end
          if (mode_d == MODE_STOP && !entry_chg && expired) begin
            entry_d = now_ms_i; entry_chg = 1'b1; mode_d = MODE_IDLE;
          end
        end
        ACT_PULSE: begin
          if (pulse_q != '1) pulse_d = pulse_q + 1'b1;
        end
        ACT_FWD_REQ: begin
          stop_pend_d = 1'b0; bwd_pend_d = 1'b0; fwd_pend_d = 1'b1;
        end
        ACT_BWD_REQ: begin
          stop_pend_d = 1'b0; fwd_pend_d = 1'b0; bwd_pend_d = 1'b1;
        end
        ACT_STOP_REQ: begin
          fwd_pend_d = 1'b0; bwd_pend_d = 1'b0; stop_pend_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      pulse_d  = '0;
      rpm_d    = sat_q ? RPM_MAX : quot_q;
      sample_d = now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      fwd_held_q  <= 1'b0;
      bwd_held_q  <= 1'b0;
      fwd_pend_q  <= 1'b0;
      bwd_pend_q  <= 1'b0;
      stop_pend_q <= 1'b0;
      entry_q     <= '0;
      sample_q    <= '0;
      pulse_q     <= '0;
      rpm_q       <= '0;
      spin_q      <= SPIN_OFF_RST;
      ppr_q       <= PPR_RST;
    end else begin
      mode_q      <= mode_d;
      fwd_held_q  <= fwd_held_d;
      bwd_held_q  <= bwd_held_d;
      fwd_pend_q  <= fwd_pend_d;
      bwd_pend_q  <= bwd_pend_d;
      stop_pend_q <= stop_pend_d;
      entry_q     <= entry_d;
      sample_q    <= sample_d;
      pulse_q     <= pulse_d;
      rpm_q       <= rpm_d;
      if (cfg_we_i && cfg_index_i == CFG_SPIN_OFF) spin_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_index_i == CFG_PPR)      ppr_q  <= cfg_wdata_i;
    end
  end

  // divider: first step checks quotient overflow (a zero divisor lands there
  // too), then one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      num_q <= NumW'(pulse_q) * NumW'(MS_PER_MIN);
      den_q <= DenW'(elapsed_ms) * DenW'(ppr_q);
      now_q <= now_ms_i;
    end
    if (cmd_i.prep) begin
      rem_q  <= num_q;
      dsr_q  <= {den_q, {QuotW{1'b0}}};
      cnt_q  <= CntW'(QuotW);
      sat_q  <= 1'b0;
      quot_q <= '0;
    end
    if (cmd_i.step) begin
      if (cnt_q == CntW'(QuotW)) begin
        sat_q <= ge;
      end else begin
        quot_q <= {quot_q[QuotW-2:0], ge};
        if (ge) rem_q <= rem_q - dsr_q[NumW-1:0];
      end
      dsr_q <= dsr_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: design/ac_motor_direction_controller.sv
// ----------------------------------------------------------------------------
// ac_motor_direction_controller
// Reversing AC motor sequencer with relay drive and tacho rpm measurement.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_axis channel, the kind of request in tuser
// (refresh, rpm tick, tacho pulse, forward, backward, stop) and the button
// levels with the millisecond time stamp in tdata. Every request gives one
// result on m_axis: mode, four relay drives, running flag and last rpm.
// Configuration (spin-off seconds, pulses per revolution) is to be written through
// the cfg port while no request is in flight; the block does not enforce this.
// A result is valid the cycle after its request is accepted; an rpm tick
// outside idle runs the restoring divider and gives its result after a set-up
// state, 17 divider steps and a write-back.
// Throughput: one request per cycle for all but the rpm tick, while m_axis
// takes results; an rpm tick blocks new requests until its result is set.
// Reset puts the motor in idle with all relays off, rpm zero, spin-off 10 s
// and one pulse per revolution. While a result waits unaccepted on m_axis,
// s_axis_tready stays low and no new request is taken.
// ----------------------------------------------------------------------------
module ac_motor_direction_controller import acmdc_pkg::*; #(
  parameter int unsigned PULSE_WIDTH = PulseWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // forward_button_down, backward_button_down, now_ms[31:0], zero pad
  input  logic [39:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_mode[1:0], power_relay, brush_relay, coil_one_relay, coil_two_relay,
  // running, speed_rpm[15:0], zero pad
  output logic [23:0] m_axis_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  acmdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  acmdc_datapath #(
    .PULSE_WIDTH (PULSE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (s_axis_tuser),
    .fwd_down_i  (s_axis_tdata[0]),
    .bwd_down_i  (s_axis_tdata[1]),
    .now_ms_i    (s_axis_tdata[33:2]),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

  assign m_axis_tdata = {1'b0, result};

endmodule

// File: tb/acmdc_checker.sv
// ----------------------------------------------------------------------------
// acmdc_checker
// Watches the request, result and cfg ports of the motor sequencer, keeps its
// own copy of the mode, request flags, tacho count and rpm, and compares every
// result word field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
module acmdc_checker import acmdc_pkg::*; #(
  parameter int unsigned PULSE_WIDTH = PulseWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [3:0] RLY_POWER = 4'b0001;
  localparam logic [3:0] RLY_ALL   = 4'b1111;
  localparam logic [PULSE_WIDTH-1:0] PULSE_SAT = '1;

  logic [7:0]             spin_s;
  logic [7:0]             ppr;
  mode_e                  mode;
  logic                   fwd_held, bwd_held;
  logic                   fwd_pend, bwd_pend, stop_pend;
  logic [31:0]            entry_ms;
  logic [31:0]            sample_ms;
  logic [PULSE_WIDTH-1:0] pulses;
  logic [15:0]            rpm;
  logic [3:0]             relays;

  result_t status_q[$];
  int      mismatches;
  int      checked;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("result %0d: %s got %0h, expected %0h", checked, what, got, want);
  endtask

  task automatic enter_idle(input logic [31:0] now);
    if (mode != MODE_IDLE) entry_ms = now;
    relays = '0;
    mode   = MODE_IDLE;
  endtask

  task automatic enter_stopping(input logic [31:0] now);
    logic [31:0] hold_ms;
    logic [31:0] spent_ms;
    hold_ms = 32'(spin_s) * 32'd1000;
    if (mode != MODE_STOP) entry_ms = now;
    relays   = '0;
    spent_ms = now - entry_ms;
    if (spent_ms > hold_ms) enter_idle(now);
    else mode = MODE_STOP;
  endtask

  task automatic enter_direction(input mode_e dir, input logic [31:0] now);
    if (mode == MODE_IDLE) begin
      entry_ms  = now;
      relays    = (dir == MODE_FWD) ? RLY_POWER : RLY_ALL;
      pulses    = '0;
      rpm       = '0;
      sample_ms = now;
      if (dir == MODE_FWD) fwd_pend = 1'b0;
      else bwd_pend = 1'b0;
      mode = dir;
    end else if (mode != dir) begin
      // reversal goes through stopping, the new direction waits as pending
      if (dir == MODE_FWD) fwd_pend = 1'b1;
      else bwd_pend = 1'b1;
      enter_stopping(now);
    end
  endtask

  task automatic sample_buttons(input logic fdown, input logic bdown, input logic [31:0] now);
    if (fdown) begin
      fwd_held = 1'b1;
      fwd_pend = 1'b1;
    end else if (fwd_held) begin
      fwd_held  = 1'b0;
      fwd_pend  = 1'b0;
      stop_pend = 1'b1;
    end
    if (bdown) begin
      bwd_held = 1'b1;
      bwd_pend = 1'b1;
    end else if (bwd_held) begin
      bwd_held  = 1'b0;
      bwd_pend  = 1'b0;
      stop_pend = 1'b1;
    end
    if (stop_pend) begin
      stop_pend = 1'b0;
      if (mode != MODE_IDLE) enter_stopping(now);
    end
    if (fwd_pend && mode != MODE_STOP) enter_direction(MODE_FWD, now);
    if (bwd_pend && mode != MODE_STOP) enter_direction(MODE_BWD, now);
    if (mode == MODE_STOP) enter_stopping(now);
  endtask

  task automatic measure_rpm(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] divisor;
    logic [63:0] quot;
    if (mode == MODE_IDLE) return;
    elapsed = now - sample_ms;
    divisor = 64'(elapsed) * 64'(ppr);
    if (divisor == 64'd0) begin
      quot = 64'(RPM_MAX);
    end else begin
      quot = (64'(pulses) * 64'(MS_PER_MIN)) / divisor;
      if (quot > 64'(RPM_MAX)) quot = 64'(RPM_MAX);
    end
    rpm       = quot[15:0];
    pulses    = '0;
    sample_ms = now;
  endtask

  task automatic apply_request(input logic [2:0] act, input logic fdown, input logic bdown,
                               input logic [31:0] now);
    case (act)
      ACT_REFRESH:  sample_buttons(fdown, bdown, now);
      ACT_RPM_TICK: measure_rpm(now);
      ACT_PULSE: begin
        if (pulses != PULSE_SAT) pulses = pulses + 1'b1;
      end
      ACT_FWD_REQ: begin
        stop_pend = 1'b0;
        bwd_pend  = 1'b0;
        fwd_pend  = 1'b1;
      end
      ACT_BWD_REQ: begin
        fwd_pend  = 1'b0;
        stop_pend = 1'b0;
        bwd_pend  = 1'b1;
      end
      ACT_STOP_REQ: begin
        bwd_pend  = 1'b0;
        fwd_pend  = 1'b0;
        stop_pend = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic result_t current_status();
    result_t st;
    st.motor_mode     = mode;
    st.power_relay    = relays[0];
    st.brush_relay    = relays[1];
    st.coil_one_relay = relays[2];
    st.coil_two_relay = relays[3];
    st.running        = (mode == MODE_FWD) || (mode == MODE_BWD);
    st.speed_rpm      = rpm;
    return st;
  endfunction

  task automatic check_status(input result_t got);
    result_t want;
    if (status_q.size() == 0) begin
      report_mismatch("result with nothing expected, word", 32'(got), 32'd0);
      return;
    end
    want = status_q.pop_front();
    if (got.motor_mode !== want.motor_mode)
      report_mismatch("motor_mode", 32'(got.motor_mode), 32'(want.motor_mode));
    if (got.power_relay !== want.power_relay)
      report_mismatch("power_relay", 32'(got.power_relay), 32'(want.power_relay));
    if (got.brush_relay !== want.brush_relay)
      report_mismatch("brush_relay", 32'(got.brush_relay), 32'(want.brush_relay));
    if (got.coil_one_relay !== want.coil_one_relay)
      report_mismatch("coil_one_relay", 32'(got.coil_one_relay), 32'(want.coil_one_relay));
    if (got.coil_two_relay !== want.coil_two_relay)
      report_mismatch("coil_two_relay", 32'(got.coil_two_relay), 32'(want.coil_two_relay));
    if (got.running !== want.running)
      report_mismatch("running", 32'(got.running), 32'(want.running));
    if (got.speed_rpm !== want.speed_rpm)
      report_mismatch("speed_rpm", 32'(got.speed_rpm), 32'(want.speed_rpm));
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_s     = SPIN_OFF_RST;
      ppr        = PPR_RST;
      mode       = MODE_IDLE;
      fwd_held   = 1'b0;
      bwd_held   = 1'b0;
      fwd_pend   = 1'b0;
      bwd_pend   = 1'b0;
      stop_pend  = 1'b0;
      entry_ms   = '0;
      sample_ms  = '0;
      pulses     = '0;
      rpm        = '0;
      relays     = '0;
      mismatches = 0;
      checked    = 0;
      status_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // the result leaving now was predicted earlier, so compare before pushing
      if (m_tvalid_i && m_tready_i) check_status(result_t'(m_tdata_i[22:0]));
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SPIN_OFF) spin_s = cfg_wdata_i;
        else ppr = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_request(s_tuser_i, s_tdata_i[0], s_tdata_i[1], s_tdata_i[33:2]);
        status_q.push_back(current_status());
      end
      mismatches_o <= mismatches;
      pending_o    <= status_q.size();
      checked_o    <= checked;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the reversing motor sequencer: a directed walk
// through every mode, request kind and the rpm corner cases, then phases of
// random button, request, tacho and tick traffic under several settings,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import acmdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned TAIL_CYCLES     = 40;
  // narrow tacho counter so a short burst reaches saturation
  localparam int unsigned PULSE_W         = 8;
  localparam int unsigned BURST_PULSES    = 260;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 62;
  localparam logic [2:0]  ACT_SPARE_LO    = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI    = 3'd7;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;

  int          mismatches;
  int          pending;
  int          checked;
  bit          quiet      = 1'b0;
  int          ready_wait = 0;
  int          ready_draw;
  int          cycles     = 0;
  int          sent       = 0;
  int          cur_spin   = 10;
  logic [31:0] clock_ms   = 32'd30000;
  bit          hold_fwd   = 1'b0;
  bit          hold_bwd   = 1'b0;

  always #2 clk_i = ~clk_i;

  ac_motor_direction_controller #(.PULSE_WIDTH(PULSE_W)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  acmdc_checker #(.PULSE_WIDTH(PULSE_W)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // result side: a fresh random stall after every accepted result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      ready_wait <= 2;
    end else if (m_tvalid && m_tready) begin
      ready_draw = quiet ? 0 : $urandom_range(0, 8);
      ready_wait <= ready_draw;
      m_tready   <= (ready_draw == 0);
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      m_tready   <= (ready_wait == 1);
    end
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("run stopped at the cycle limit, %0d results still due", pending);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic [2:0] act, input bit fdown, input bit bdown,
                           input logic [31:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'b0, now, bdown, fdown};
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [7:0] spin, input logic [7:0] ppr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPIN_OFF;
    cfg_wdata <= spin;
    @(posedge clk_i);
    cfg_index <= CFG_PPR;
    cfg_wdata <= ppr;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_spin = int'(spin);
  endtask

  task automatic run_directed();
    send_item(ACT_RPM_TICK, 1'b0, 1'b0, 32'd5);          // tick in idle is ignored
    send_item(ACT_PULSE, 1'b1, 1'b1, 32'hFFFF_FFFF);    // pulses count in idle too
    send_item(ACT_SPARE_LO, 1'b1, 1'b0, 32'd0);
    send_item(ACT_SPARE_HI, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_REFRESH, 1'b1, 1'b0, 32'd1000);       // button press starts forward
    repeat (3) send_item(ACT_PULSE, 1'b0, 1'b0, 32'd1000);
    send_item(ACT_RPM_TICK, 1'b0, 1'b0, 32'd1000);      // zero elapsed time
    repeat (2) send_item(ACT_PULSE, 1'b0, 1'b0, 32'd1200);
    send_item(ACT_RPM_TICK, 1'b0, 1'b0, 32'd1500);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd2000);       // release asks for a stop
    send_item(ACT_RPM_TICK, 1'b0, 1'b0, 32'd2500);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd12000);      // spin-off just reached
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd12001);      // and now passed
    send_item(ACT_BWD_REQ, 1'b0, 1'b0, 32'd12001);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd13000);
    send_item(ACT_FWD_REQ, 1'b0, 1'b0, 32'd13500);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd14000);      // reversal through stopping
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd24001);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd24002);      // pending forward starts
    quiet <= 1'b1;
    repeat (BURST_PULSES) send_item(ACT_PULSE, 1'b0, 1'b0, 32'd24002);
    quiet <= 1'b0;
    send_item(ACT_RPM_TICK, 1'b0, 1'b0, 32'd24003);     // saturated count and rpm
    send_item(ACT_STOP_REQ, 1'b0, 1'b0, 32'd24500);
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'd25000);
    send_item(ACT_REFRESH, 1'b1, 1'b1, 32'hFFFF_FF00);  // both buttons, long wait
    send_item(ACT_REFRESH, 1'b1, 1'b1, 32'h0000_0100);  // time stamp wraps
    send_item(ACT_REFRESH, 1'b0, 1'b0, 32'h0000_0200);
  endtask

  task automatic random_item();
    int          pick;
    int          sel;
    logic [2:0]  act;
    bit          fdown;
    bit          bdown;
    pick = $urandom_range(0, 99);
    if (pick < 36) act = ACT_REFRESH;
    else if (pick < 64) act = ACT_PULSE;
    else if (pick < 78) act = ACT_RPM_TICK;
    else if (pick < 84) act = ACT_FWD_REQ;
    else if (pick < 90) act = ACT_BWD_REQ;
    else if (pick < 95) act = ACT_STOP_REQ;
    else act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
    // button levels stay put for a while so presses and releases look real
    if (act == ACT_REFRESH) begin
      if ($urandom_range(0, 99) < 20) hold_fwd = ~hold_fwd;
      if ($urandom_range(0, 99) < 20) hold_bwd = ~hold_bwd;
      fdown = hold_fwd;
      bdown = hold_bwd;
    end else begin
      fdown = 1'($urandom_range(0, 1));
      bdown = 1'($urandom_range(0, 1));
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) clock_ms = clock_ms + $urandom_range(0, 200);
    else if (sel < 78) clock_ms = clock_ms + $urandom_range(0, 1500);
    else if (sel < 96) clock_ms = clock_ms + $urandom_range(0, cur_spin * 1000 + 2000);
    else clock_ms = $urandom();
    send_item(act, fdown, bdown, clock_ms);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_settings(8'd0, 8'd1);
        1: write_settings(8'd255, 8'd255);
        2: write_settings(8'd1, 8'd7);
        3: write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
        4: write_settings(8'd3, 8'd1);
        default: write_settings(8'($urandom_range(0, 20)), 8'd255);
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 35 == 0) quiet <= ($urandom_range(0, 3) == 0);
        random_item();
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d requests sent, %0d results compared, %0d settings phases after reset",
             sent, checked, PHASES);
    $display("covered mode walk, reversal, spin-off edges, zero elapsed, count saturation");
    if (pending != 0) $display("%0d results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
